>>> hdl/mfcsv_pkg.sv
// Shared types, codes and constant tables of the framed CSV record parser.
package mfcsv_pkg;

  localparam int unsigned MaxCharsDef   = 32;
  localparam int unsigned FracDigitsDef = 4;

  localparam int unsigned FRAC_W  = 17;  // holds up to five fraction digits
  localparam int unsigned NDIG_W  = 3;   // fraction digit count, 0..5
  localparam int unsigned RECIP_W = 30;
  localparam int unsigned FIDX_W  = 3;

  // field positions within a record
  localparam logic [FIDX_W-1:0] FLD_SUB_OPT = 3'd2;
  localparam logic [FIDX_W-1:0] FLD_TYPE    = 3'd3;
  localparam logic [FIDX_W-1:0] FLD_VALUE   = 3'd4;
  localparam logic [FIDX_W-1:0] FLD_LAST    = 3'd5;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [0:0] {
    REG_START_MARKER = 1'b0,
    REG_END_MARKER   = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_I16 = 2'd0,
    KIND_I32 = 2'd1,
    KIND_Q16 = 2'd2,
    KIND_BAD = 2'd3
  } value_kind_e;

  typedef enum logic [5:0] {
    PH_BETWEEN = 6'b000001,
    PH_BLANKS  = 6'b000010,
    PH_DIGITS  = 6'b000100,
    PH_SKIP    = 6'b001000,
    PH_FRAC    = 6'b010000,
    PH_ENDED   = 6'b100000
  } phase_e;

  // one closed record on its way through the value pipeline
  typedef struct packed {
    logic [15:0]       primary;
    logic [15:0]       option;
    logic [15:0]       sub_option;
    value_kind_e       kind;
    logic [31:0]       int_acc;
    logic [FRAC_W-1:0] frac;
    logic [NDIG_W-1:0] ndig;
    logic              neg;
    logic              trunc;
    logic [15:0]       frac_q;
  } rec_t;

  function automatic value_kind_e kind_of(input logic [7:0] t);
    value_kind_e k;
    case (t)
      8'h69, 8'h49: k = KIND_I16;  // i I
      8'h6c, 8'h4c: k = KIND_I32;  // l L
      8'h66, 8'h46: k = KIND_Q16;  // f F
      default:      k = KIND_BAD;
    endcase
    return k;
  endfunction

  function automatic logic [FRAC_W-1:0] pow10_f(input logic [NDIG_W-1:0] n);
    logic [FRAC_W-1:0] p;
    case (n)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      3'd5:    p = 17'd100000;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

  // floor(2^33 / 10^n); zero for n = 0, where the fraction is zero anyway
  function automatic logic [RECIP_W-1:0] recip_f(input logic [NDIG_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      3'd1:    r = 30'd858993459;
      3'd2:    r = 30'd85899345;
      3'd3:    r = 30'd8589934;
      3'd4:    r = 30'd858993;
      3'd5:    r = 30'd85899;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/marker_framed_csv_record_parser_core.sv
// Top level: byte-wise framed CSV record parser with a four-stage result pipeline.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   cfg     | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o | in_byte_i
//   out     | out       | out_valid_o/out_ready_i | primary_o, option_o, sub_option_o,
//           |           |                       | value_kind_o, value_o, truncated_o
//
// One byte beat is taken every cycle while in_ready_o is high; the parser updates its
// field state in the cycle of the beat. An end-marker beat hands the record to a
// four-register pipeline (snapshot, reciprocal multiply, correction multiply,
// output). The two multiply stages carry out the fraction scaling by 65536/10^n.
// A stalled output fills the pipeline back to the input; bubbles collapse.
// Reset restores the markers to '<' and '>' and empties the pipeline.
module marker_framed_csv_record_parser_core
  import mfcsv_pkg::*;
#(
  parameter int unsigned MAX_CHARS   = MaxCharsDef,
  parameter int unsigned FRAC_DIGITS = FracDigitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] primary_o,
  output logic signed [15:0] option_o,
  output logic signed [15:0] sub_option_o,
  output logic [1:0]         value_kind_o,
  output logic signed [31:0] value_o,
  output logic               truncated_o
);

  localparam int unsigned CNT_W  = (MAX_CHARS > 2) ? $clog2(MAX_CHARS) : 1;
  localparam int unsigned FCNT_W = $clog2(FRAC_DIGITS + 1);
  localparam logic [CNT_W-1:0]  CntLimit  = CNT_W'(MAX_CHARS - 1);
  localparam logic [FCNT_W-1:0] FracLimit = FCNT_W'(FRAC_DIGITS);

  // configuration
  logic [7:0] start_mark_q, end_mark_q;

  // parser state
  logic              in_frame_q, in_frame_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FIDX_W-1:0] fidx_q, fidx_d;
  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [15:0]       prim_q, prim_d, opt_q, opt_d, sub_q, sub_d;
  logic [7:0]        type_q, type_d;
  logic [31:0]       int_q, int_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [FCNT_W-1:0] fcnt_q, fcnt_d;
  logic              ovf_q, ovf_d;

  // pipeline
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  rec_t s1_q, s2_q, s3_q;
  logic move_out, move3, move2, s3_free, s2_free, s1_free;
  logic in_acc, end_acc;

  // per-byte decode
  logic [7:0]  c;
  logic        is_blank, is_digit, numeric;
  logic [3:0]  dig;
  value_kind_e cur_kind;
  phase_e      eff_phase;
  logic        neg_eff;
  logic [15:0] acc_sel, acc_new;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_mark_q <= 8'd60;
      end_mark_q   <= 8'd62;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_START_MARKER: start_mark_q <= cfg_data_i;
        REG_END_MARKER:   end_mark_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline flow: each stage advances when the next one is free
  // ---------------------------------------------------------------------------
  assign move_out   = s3_v_q && (!out_v_q || out_ready_i);
  assign s3_free    = !s3_v_q || move_out;
  assign move3      = s2_v_q && s3_free;
  assign s2_free    = !s2_v_q || move3;
  assign move2      = s1_v_q && s2_free;
  assign s1_free    = !s1_v_q || move2;
  assign in_ready_o = s1_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign end_acc    = in_acc && in_frame_q && (in_byte_i == end_mark_q);

  // ---------------------------------------------------------------------------
  // Byte parser: one character per beat, fields accumulated on the fly
  // ---------------------------------------------------------------------------
  assign c        = in_byte_i;
  assign is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dig      = c[3:0];
  assign cur_kind = kind_of(type_q);

  always_comb begin
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    fidx_d     = fidx_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    prim_d     = prim_q;
    opt_d      = opt_q;
    sub_d      = sub_q;
    type_d     = type_q;
    int_d      = int_q;
    frac_d     = frac_q;
    fcnt_d     = fcnt_q;
    ovf_d      = ovf_q;
    eff_phase  = phase_q;
    neg_eff    = neg_q;
    numeric    = 1'b0;

    case (fidx_q)
      3'd0:    acc_sel = prim_q;
      3'd1:    acc_sel = opt_q;
      default: acc_sel = sub_q;
    endcase

    if (fidx_q == FLD_VALUE || fidx_q == FLD_LAST) begin
      neg_eff = neg_q;
    end
    if (phase_q == PH_BETWEEN && fidx_q <= FLD_VALUE) begin
      neg_eff = 1'b0;
    end
    acc_new = neg_eff ? ((acc_sel << 3) + (acc_sel << 1) - 16'(dig))
                      : ((acc_sel << 3) + (acc_sel << 1) + 16'(dig));

    if (in_acc) begin
      if (!in_frame_q) begin
        // open a record on the start marker, drop everything else
        if (c == start_mark_q) begin
          in_frame_d = 1'b1;
          cnt_d      = '0;
          fidx_d     = '0;
          phase_d    = PH_BETWEEN;
          neg_d      = 1'b0;
          prim_d     = '0;
          opt_d      = '0;
          sub_d      = '0;
          type_d     = '0;
          int_d      = '0;
          frac_d     = '0;
          fcnt_d     = '0;
          ovf_d      = 1'b0;
        end
      end else if (c == end_mark_q) begin
        // close the record; its snapshot goes to the pipeline
        in_frame_d = 1'b0;
        cnt_d      = '0;
        fidx_d     = '0;
        phase_d    = PH_BETWEEN;
        neg_d      = 1'b0;
        prim_d     = '0;
        opt_d      = '0;
        sub_d      = '0;
        type_d     = '0;
        int_d      = '0;
        frac_d     = '0;
        fcnt_d     = '0;
        ovf_d      = 1'b0;
      end else if (cnt_q >= CntLimit) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
        if (phase_q == PH_ENDED) begin
          // text ended at a NUL: ignore the rest
        end else if (c == CH_NUL) begin
          phase_d = PH_ENDED;
        end else if (c == CH_COMMA) begin
          // empty fields collapse: only a field that saw text advances
          if (phase_q != PH_BETWEEN) begin
            if (fidx_q < FLD_LAST) begin
              fidx_d = fidx_q + 1'b1;
            end
            phase_d = PH_BETWEEN;
          end
        end else if (phase_q == PH_BETWEEN && fidx_q == FLD_TYPE) begin
          neg_d   = 1'b0;
          type_d  = c;
          phase_d = PH_SKIP;
        end else begin
          neg_d = neg_eff;
          if (phase_q == PH_BETWEEN) begin
            eff_phase = PH_BLANKS;
            phase_d   = PH_BLANKS;
          end
          numeric = (fidx_q <= FLD_SUB_OPT) ||
                    (fidx_q == FLD_VALUE && cur_kind != KIND_BAD);
          if (!numeric) begin
            phase_d = PH_SKIP;
          end else begin
            case (eff_phase)
              PH_BLANKS, PH_DIGITS: begin
                if (eff_phase == PH_BLANKS && is_blank) begin
                  phase_d = PH_BLANKS;
                end else if (eff_phase == PH_BLANKS &&
                             (c == CH_PLUS || c == CH_MINUS)) begin
                  neg_d   = neg_eff || (c == CH_MINUS);
                  phase_d = PH_DIGITS;
                end else if (is_digit) begin
                  phase_d = PH_DIGITS;
                  case (fidx_q)
                    3'd0:      prim_d = acc_new;
                    3'd1:      opt_d  = acc_new;
                    FLD_SUB_OPT: sub_d = acc_new;
                    default:   int_d  = (int_q << 3) + (int_q << 1) + 32'(dig);
                  endcase
                end else if (c == CH_DOT && fidx_q == FLD_VALUE &&
                             cur_kind == KIND_Q16) begin
                  phase_d = PH_FRAC;
                end else begin
                  phase_d = PH_SKIP;
                end
              end
              PH_FRAC: begin
                if (is_digit) begin
                  // digits past the kept ones truncate
                  if (fcnt_q < FracLimit) begin
                    frac_d = (frac_q << 3) + (frac_q << 1) + FRAC_W'(dig);
                    fcnt_d = fcnt_q + 1'b1;
                  end
                end else begin
                  phase_d = PH_SKIP;
                end
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      cnt_q      <= '0;
      fidx_q     <= '0;
      phase_q    <= PH_BETWEEN;
      neg_q      <= 1'b0;
      prim_q     <= '0;
      opt_q      <= '0;
      sub_q      <= '0;
      type_q     <= '0;
      int_q      <= '0;
      frac_q     <= '0;
      fcnt_q     <= '0;
      ovf_q      <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
      fidx_q     <= fidx_d;
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      prim_q     <= prim_d;
      opt_q      <= opt_d;
      sub_q      <= sub_d;
      type_q     <= type_d;
      int_q      <= int_d;
      frac_q     <= frac_d;
      fcnt_q     <= fcnt_d;
      ovf_q      <= ovf_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result pipeline
  //   s1: snapshot of the closed record
  //   s2: q0 = floor(frac * floor(2^33/10^n) / 2^17), at most one below the
  //       exact floor(frac * 65536 / 10^n)
  //   s3: bump q0 when (q0+1) * 10^n still fits under frac * 65536
  //   out: assemble, apply sign, narrow int16
  // ---------------------------------------------------------------------------
  rec_t                     snap;
  logic [FRAC_W+RECIP_W-1:0] prod1;
  logic [16:0]              q_inc;
  logic [33:0]              prod2;
  logic                     bump;
  logic [31:0]              mag, sval, val_d;

  always_comb begin
    snap            = '0;
    snap.primary    = prim_q;
    snap.option     = opt_q;
    snap.sub_option = sub_q;
    snap.kind       = cur_kind;
    snap.int_acc    = int_q;
    snap.frac       = frac_q;
    snap.ndig       = NDIG_W'(fcnt_q);
    snap.neg        = neg_q;
    snap.trunc      = ovf_q;
    snap.frac_q     = '0;
  end

  assign prod1 = s1_q.frac * recip_f(s1_q.ndig);
  assign q_inc = {1'b0, s2_q.frac_q} + 17'd1;
  assign prod2 = q_inc * pow10_f(s2_q.ndig);
  assign bump  = prod2 <= {1'b0, s2_q.frac, 16'h0000};

  always_comb begin
    mag  = (s3_q.kind == KIND_Q16) ? {s3_q.int_acc[15:0], s3_q.frac_q} : s3_q.int_acc;
    sval = s3_q.neg ? (32'd0 - mag) : mag;
    case (s3_q.kind)
      KIND_I16: val_d = {{16{sval[15]}}, sval[15:0]};
      KIND_I32: val_d = sval;
      KIND_Q16: val_d = sval;
      default:  val_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= (s1_v_q && !move2) || end_acc;
      s2_v_q  <= (s2_v_q && !move3) || move2;
      s3_v_q  <= (s3_v_q && !move_out) || move3;
      out_v_q <= (out_v_q && !out_ready_i) || move_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_acc) begin
      s1_q <= snap;
    end
    if (move2) begin
      s2_q        <= s1_q;
      s2_q.frac_q <= prod1[32:17];
    end
    if (move3) begin
      s3_q        <= s2_q;
      s3_q.frac_q <= s2_q.frac_q + 16'(bump);
    end
    if (move_out) begin
      primary_o    <= s3_q.primary;
      option_o     <= s3_q.option;
      sub_option_o <= s3_q.sub_option;
      value_kind_o <= s3_q.kind;
      value_o      <= val_d;
      truncated_o  <= s3_q.trunc;
    end
  end

  assign out_valid_o = out_v_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_v_q && s2_v_q && s3_v_q && out_v_q && !out_ready_i))
    else $error("input stalled with room in the result pipeline");

  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && value_kind_o == KIND_BAD) |-> (value_o == 32'sd0))
    else $error("invalid type letter with nonzero value");

  a_i16_sext : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && value_kind_o == KIND_I16) |-> (value_o[31:16] == {16{value_o[15]}}))
    else $error("int16 value not sign-extended");

  a_field_rng : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fidx_q <= FLD_LAST) && (cnt_q <= CntLimit))
    else $error("field index or character count out of range");

  a_frac_rng : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (s2_q.frac_q <= 16'hffff) && ({1'b0, s2_q.frac} < pow10_f(s2_q.ndig) + 17'd0
      || s2_q.ndig == 3'd0))
    else $error("fraction exceeds its digit count");

endmodule
